// ===== rtl/lmfb_pkg.sv =====
package lmfb_pkg;

    // Default panel shape and chain length
    localparam int BLOCKS_WIDE_DEF   = 1;
    localparam int BLOCKS_HIGH_DEF   = 1;
    localparam int CHAIN_MODULES_DEF = 4;

    // Widest store index over the whole parameter range (2 x 2 blocks, 128 rows)
    localparam int IDX_MAX_W = 7;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Row geometry of one 8x8 module
    localparam int ROWS_PER_MOD = 8;
    localparam logic [2:0] ROW_LAST = 3'd7;

    // Input mode codes
    localparam logic [1:0] MODE_PIXEL   = 2'd0;
    localparam logic [1:0] MODE_CLEAR   = 2'd1;
    localparam logic [1:0] MODE_REFRESH = 2'd2;
    localparam logic [1:0] MODE_INIT    = 2'd3;

    // Driver register addresses used by the init sequence
    localparam logic [3:0] REG_DECODE    = 4'h9;
    localparam logic [3:0] REG_INTENSITY = 4'hA;
    localparam logic [3:0] REG_SCAN      = 4'hB;
    localparam logic [3:0] REG_SHUTDOWN  = 4'hC;
    localparam logic [3:0] REG_TEST      = 4'hF;

    // Data bytes of the init sequence
    localparam logic [7:0] DATA_ZERO       = 8'h00;
    localparam logic [7:0] SCAN_ALL_ROWS   = 8'h07;
    localparam logic [7:0] SHUTDOWN_NORMAL = 8'h01;
    localparam logic [7:0] PIXEL_MSB       = 8'h80;

    // Init sequence steps
    localparam logic [2:0] INIT_DECODE    = 3'd0;
    localparam logic [2:0] INIT_INTENSITY = 3'd1;
    localparam logic [2:0] INIT_SCAN      = 3'd2;
    localparam logic [2:0] INIT_SHUTDOWN  = 3'd3;
    localparam logic [2:0] INIT_TEST      = 3'd4;

    // Configuration register map
    localparam logic REG_IDX_BRIGHTNESS = 1'b0;
    localparam logic [3:0] BRIGHTNESS_RESET = 4'd8;

    typedef enum logic [1:0] {
        CMD_PIXEL,
        CMD_CLEAR,
        CMD_REFRESH,
        CMD_INIT
    } cmd_t;

    typedef struct packed {
        cmd_t                 cmd;
        logic [IDX_MAX_W-1:0] idx;
        logic [2:0]           col;
        logic                 on;
    } cmd_entry_t;

    typedef struct packed {
        logic       valid;
        cmd_entry_t entry;
    } queue_link_t;

    typedef struct packed {
        logic       valid;
        logic [3:0] address;
        logic [7:0] data;
        logic       latch;
        logic       last;
    } result_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_PIX_WR,
        BK_REFRESH,
        BK_INIT
    } back_state_t;

    function automatic logic [3:0] init_addr(input logic [2:0] step);
        logic [3:0] a;
        unique case (step)
            INIT_DECODE:    a = REG_DECODE;
            INIT_INTENSITY: a = REG_INTENSITY;
            INIT_SCAN:      a = REG_SCAN;
            INIT_SHUTDOWN:  a = REG_SHUTDOWN;
            INIT_TEST:      a = REG_TEST;
            default:        a = REG_TEST;
        endcase
        return a;
    endfunction

    function automatic logic [7:0] init_data(input logic [2:0] step, input logic [3:0] bright);
        logic [7:0] d;
        unique case (step)
            INIT_INTENSITY: d = {4'd0, bright};
            INIT_SCAN:      d = SCAN_ALL_ROWS;
            INIT_SHUTDOWN:  d = SHUTDOWN_NORMAL;
            default:        d = DATA_ZERO;
        endcase
        return d;
    endfunction

endpackage

// ===== rtl/lmfb_front.sv =====
module lmfb_front #(
    parameter int BLOCKS_WIDE = 1,
    parameter int BLOCKS_HIGH = 1
) (
    input  logic                  accept,
    input  logic [1:0]            mode,
    input  logic [4:0]            x,
    input  logic [4:0]            y,
    input  logic                  pixel_on,
    output lmfb_pkg::queue_link_t push
);
    import lmfb_pkg::*;

    localparam logic [5:0] PANEL_W = 6'(16 * BLOCKS_WIDE);
    localparam logic [5:0] PANEL_H = 6'(16 * BLOCKS_HIGH);

    logic in_range;

    // Classify the transaction and locate the row byte of a pixel
    always_comb
    begin
        int unsigned blk;
        int unsigned quad;
        blk  = int'(y[4]) * BLOCKS_WIDE + int'(x[4]);
        quad = int'({y[3], x[3]});
        in_range = ({1'b0, x} < PANEL_W) && ({1'b0, y} < PANEL_H);

        push.entry.idx = IDX_MAX_W'((blk * 4 + quad) * ROWS_PER_MOD + int'(y[2:0]));
        push.entry.col = x[2:0];
        push.entry.on  = pixel_on;

        unique case (mode)
            MODE_PIXEL:   push.entry.cmd = CMD_PIXEL;
            MODE_CLEAR:   push.entry.cmd = CMD_CLEAR;
            MODE_REFRESH: push.entry.cmd = CMD_REFRESH;
            MODE_INIT:    push.entry.cmd = CMD_INIT;
            default:      push.entry.cmd = CMD_INIT;
        endcase

        // Drop pixel writes that fall outside the panel
        push.valid = accept && ((mode != MODE_PIXEL) || in_range);
    end

endmodule

// ===== rtl/lmfb_queue.sv =====
module lmfb_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lmfb_pkg::queue_link_t push,
    input  logic                  pop,
    output lmfb_pkg::queue_link_t head,
    output logic                  full
);
    import lmfb_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [PTR_W:0]   CNT_FULL = (PTR_W + 1)'(QUEUE_DEPTH);

    cmd_entry_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign do_push = push.valid && !full;
    assign do_pop  = pop && (count_reg != '0);

    assign head.valid = (count_reg != '0);
    assign head.entry = slot_reg[rd_ptr_reg];

    // Advance pointers and occupancy
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Hold queued commands
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push.entry;
        end
    end

endmodule

// ===== rtl/lmfb_back.sv =====
module lmfb_back #(
    parameter int BLOCKS_WIDE   = 1,
    parameter int BLOCKS_HIGH   = 1,
    parameter int CHAIN_MODULES = 4
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lmfb_pkg::queue_link_t head,
    input  logic [3:0]            brightness,
    output logic                  pop,
    output lmfb_pkg::result_t     result
);
    import lmfb_pkg::*;

    localparam int TOTAL_MODS  = 4 * BLOCKS_WIDE * BLOCKS_HIGH;
    localparam int MOD_W       = $clog2(TOTAL_MODS);
    localparam int IDX_W       = MOD_W + 3;
    localparam int STORE_DEPTH = TOTAL_MODS * ROWS_PER_MOD;
    localparam int CH_W        = $clog2(CHAIN_MODULES);
    localparam logic [MOD_W-1:0] MOD_LAST   = MOD_W'(TOTAL_MODS - 1);
    localparam logic [CH_W-1:0]  CHAIN_LAST = CH_W'(CHAIN_MODULES - 1);

    back_state_t state_reg, state_next;

    logic [7:0]       mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] valid_reg;
    logic [7:0]       rdata_reg;
    logic             rvalid_reg;

    logic [2:0]       row_reg, row_next;
    logic [MOD_W-1:0] mod_reg, mod_next;
    logic [2:0]       step_reg, step_next;
    logic [CH_W-1:0]  chain_reg, chain_next;

    logic [IDX_W-1:0] pend_idx_reg;
    logic [2:0]       pend_col_reg;
    logic             pend_on_reg;

    logic             st_valid_reg, st_valid_next;
    logic [3:0]       st_addr_reg, st_addr_next;
    logic [7:0]       st_data_reg, st_data_next;
    logic             st_mem_reg, st_mem_next;
    logic             st_latch_reg, st_latch_next;
    logic             st_last_reg, st_last_next;

    logic             rd_en, wr_en, clear_all;
    logic [IDX_W-1:0] rd_idx;
    logic [7:0]       old_row, mask, wr_data;
    logic             refresh_done, init_done;

    assign refresh_done = (row_reg == ROW_LAST) && (mod_reg == '0);
    assign init_done    = (step_reg == INIT_TEST) && (chain_reg == '0);

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (head.valid)
                begin
                    case (head.entry.cmd)
                        CMD_PIXEL:   state_next = BK_PIX_WR;
                        CMD_REFRESH: state_next = BK_REFRESH;
                        CMD_INIT:    state_next = BK_INIT;
                        default:     state_next = BK_IDLE;
                    endcase
                end
            end
            BK_PIX_WR:  state_next = BK_IDLE;
            BK_REFRESH: state_next = refresh_done ? BK_IDLE : BK_REFRESH;
            BK_INIT:    state_next = init_done ? BK_IDLE : BK_INIT;
            default:    state_next = BK_IDLE;
        endcase
    end

    // Outputs of the sequencer
    always_comb
    begin
        pop       = 1'b0;
        rd_en     = 1'b0;
        rd_idx    = {mod_reg, row_reg};
        wr_en     = 1'b0;
        clear_all = 1'b0;

        st_valid_next = 1'b0;
        st_addr_next  = {1'b0, row_reg} + 4'd1;
        st_data_next  = DATA_ZERO;
        st_mem_next   = 1'b1;
        st_latch_next = (mod_reg == '0);
        st_last_next  = refresh_done;

        unique case (state_reg)
            BK_IDLE:
            begin
                pop = head.valid;
                if (head.valid && head.entry.cmd == CMD_PIXEL)
                begin
                    rd_en  = 1'b1;
                    rd_idx = head.entry.idx[IDX_W-1:0];
                end
                clear_all = head.valid && (head.entry.cmd == CMD_CLEAR);
            end
            BK_PIX_WR:
            begin
                wr_en = 1'b1;
            end
            BK_REFRESH:
            begin
                rd_en         = 1'b1;
                st_valid_next = 1'b1;
            end
            BK_INIT:
            begin
                st_valid_next = 1'b1;
                st_addr_next  = init_addr(step_reg);
                st_data_next  = init_data(step_reg, brightness);
                st_mem_next   = 1'b0;
                st_latch_next = (chain_reg == '0);
                st_last_next  = init_done;
            end
            default:
            begin
                pop = 1'b0;
            end
        endcase
    end

    // Advance the refresh and init counters
    always_comb
    begin
        row_next   = row_reg;
        mod_next   = mod_reg;
        step_next  = step_reg;
        chain_next = chain_reg;
        if (state_reg == BK_IDLE)
        begin
            row_next   = '0;
            mod_next   = MOD_LAST;
            step_next  = INIT_DECODE;
            chain_next = CHAIN_LAST;
        end
        else if (state_reg == BK_REFRESH)
        begin
            if (mod_reg == '0)
            begin
                mod_next = MOD_LAST;
                row_next = row_reg + 3'd1;
            end
            else
            begin
                mod_next = mod_reg - 1'b1;
            end
        end
        else if (state_reg == BK_INIT)
        begin
            if (chain_reg == '0)
            begin
                chain_next = CHAIN_LAST;
                step_next  = step_reg + 3'd1;
            end
            else
            begin
                chain_next = chain_reg - 1'b1;
            end
        end
    end

    // Modify the row byte read for a pixel write
    always_comb
    begin
        old_row = rvalid_reg ? rdata_reg : 8'd0;
        mask    = PIXEL_MSB >> pend_col_reg;
        wr_data = pend_on_reg ? (old_row | mask) : (old_row & ~mask);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= BK_IDLE;
            st_valid_reg <= 1'b0;
            row_reg      <= '0;
            mod_reg      <= '0;
            step_reg     <= '0;
            chain_reg    <= '0;
            valid_reg    <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            st_valid_reg <= st_valid_next;
            row_reg      <= row_next;
            mod_reg      <= mod_next;
            step_reg     <= step_next;
            chain_reg    <= chain_next;
            if (clear_all)
            begin
                valid_reg <= '0;
            end
            else if (wr_en)
            begin
                valid_reg[pend_idx_reg] <= 1'b1;
            end
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[pend_idx_reg] <= wr_data;
        end
        if (rd_en)
        begin
            rdata_reg  <= mem[rd_idx];
            rvalid_reg <= valid_reg[rd_idx];
        end
    end

    // Hold the pending pixel and the output word
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pend_idx_reg <= head.entry.idx[IDX_W-1:0];
            pend_col_reg <= head.entry.col;
            pend_on_reg  <= head.entry.on;
        end
        st_addr_reg  <= st_addr_next;
        st_data_reg  <= st_data_next;
        st_mem_reg   <= st_mem_next;
        st_latch_reg <= st_latch_next;
        st_last_reg  <= st_last_next;
    end

    assign result.valid   = st_valid_reg;
    assign result.address = st_addr_reg;
    assign result.data    = st_mem_reg ? (rvalid_reg ? rdata_reg : 8'd0) : st_data_reg;
    assign result.latch   = st_latch_reg;
    assign result.last    = st_last_reg;

endmodule

// ===== rtl/led_matrix_framebuffer_refresh.sv =====
// Frame store and chain sequencer for 8x8 LED matrix driver chips, four to a
// 16x16 block. A command is taken when start is high and busy is low; busy
// rises only while the two-entry command queue is full. The back end runs one
// command at a time: a pixel write reads the row byte, then modify-writes it;
// a store clear drops every valid bit; a refresh sends one word per row of
// every module from the single read port of the frame store; an init run
// sends 5*CHAIN_MODULES words. Words appear on reg_address/reg_data for one
// cycle each with result_valid high and cannot be held off; the first word
// of a run is registered through the command queue, the back-end state and
// the output word register. After reset no clearing pass is needed: per-row
// valid bits keep the store dark. Brightness is written over APB at address 0.
module led_matrix_framebuffer_refresh #(
    parameter int BLOCKS_WIDE   = lmfb_pkg::BLOCKS_WIDE_DEF,
    parameter int BLOCKS_HIGH   = lmfb_pkg::BLOCKS_HIGH_DEF,
    parameter int CHAIN_MODULES = lmfb_pkg::CHAIN_MODULES_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  mode,
    input  logic [4:0]  x,
    input  logic [4:0]  y,
    input  logic        pixel_on,
    output logic        result_valid,
    output logic [3:0]  reg_address,
    output logic [7:0]  reg_data,
    output logic        latch,
    output logic        last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import lmfb_pkg::*;

    queue_link_t push, head;
    result_t     result;
    logic        full, pop, accept, cfg_write;
    logic [3:0]  brightness_reg;

    assign busy   = full;
    assign accept = start && !busy;

    lmfb_front #(
        .BLOCKS_WIDE (BLOCKS_WIDE),
        .BLOCKS_HIGH (BLOCKS_HIGH)
    ) u_front (
        .accept   (accept),
        .mode     (mode),
        .x        (x),
        .y        (y),
        .pixel_on (pixel_on),
        .push     (push)
    );

    lmfb_queue u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .pop   (pop),
        .head  (head),
        .full  (full)
    );

    lmfb_back #(
        .BLOCKS_WIDE   (BLOCKS_WIDE),
        .BLOCKS_HIGH   (BLOCKS_HIGH),
        .CHAIN_MODULES (CHAIN_MODULES)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .brightness (brightness_reg),
        .pop        (pop),
        .result     (result)
    );

    assign result_valid = result.valid;
    assign reg_address  = result.address;
    assign reg_data     = result.data;
    assign latch        = result.latch;
    assign last         = result.last;

    // Configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == REG_IDX_BRIGHTNESS) ? {28'd0, brightness_reg} : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            brightness_reg <= BRIGHTNESS_RESET;
        end
        else if (cfg_write && paddr[2] == REG_IDX_BRIGHTNESS)
        begin
            brightness_reg <= pwdata[3:0];
        end
    end

    // The final word of a run always closes a latch group
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && last) |-> latch)
        else $error("last word without latch");

    // Every word carries a live driver register address
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (reg_address != 4'h0))
        else $error("word with no-op register address");

    // A brightness write lands on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (cfg_write && paddr[2] == REG_IDX_BRIGHTNESS) |=> (brightness_reg == $past(pwdata[3:0])))
        else $error("brightness write lost");

endmodule
